// ===== rtl/core/i2c_master_byte_engine_unit_macros.svh =====
// Assertion macros used by the checker file of this block.
`ifndef I2C_MASTER_BYTE_ENGINE_UNIT_MACROS_SVH
`define I2C_MASTER_BYTE_ENGINE_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define I2CM_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define I2CM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/i2cm_pkg.sv =====
`default_nettype none

package i2cm_pkg;

	// Request codes carried by each tick.
	localparam logic [2:0] REQ_NONE     = 3'd0;
	localparam logic [2:0] REQ_START    = 3'd1;
	localparam logic [2:0] REQ_STOP     = 3'd2;
	localparam logic [2:0] REQ_WRITE    = 3'd3;
	localparam logic [2:0] REQ_RD_ACK   = 3'd4;
	localparam logic [2:0] REQ_RD_NACK  = 3'd5;

	// Completion status codes.
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_BUS_BUSY  = 2'd1;
	localparam logic [1:0] ST_BUS_ERR   = 2'd2;
	localparam logic [1:0] ST_NACK      = 2'd3;

	// Configuration register indexes and reset values.
	localparam int unsigned CFG_IDX_W   = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_PHASE_DELAY = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ACK_TIMEOUT = 1'd1;
	localparam logic [15:0] PHASE_DELAY_RST = 16'd4;
	localparam logic [15:0] ACK_TIMEOUT_RST = 16'd100;

	// Number of data bits in one byte transfer.
	localparam logic [3:0] BYTE_BITS = 4'd8;

	// Bus phases, one-hot.
	typedef enum logic [19:0] {
		PH_IDLE    = 20'h00001,
		PH_ST_REL  = 20'h00002,
		PH_ST_SDA  = 20'h00004,
		PH_ST_SCL  = 20'h00008,
		PH_SP_SDA  = 20'h00010,
		PH_SP_SCL  = 20'h00020,
		PH_SP_REL  = 20'h00040,
		PH_WR_SCL  = 20'h00080,
		PH_WR_BIT  = 20'h00100,
		PH_WR_HI   = 20'h00200,
		PH_WR_LO   = 20'h00400,
		PH_WR_AREL = 20'h00800,
		PH_WR_AHI  = 20'h01000,
		PH_WR_POLL = 20'h02000,
		PH_RD_PREP = 20'h04000,
		PH_RD_HI   = 20'h08000,
		PH_RD_LO   = 20'h10000,
		PH_AK_SDA  = 20'h20000,
		PH_AK_HI   = 20'h40000,
		PH_AK_LO   = 20'h80000
	} phase_t;

	// One input tick.
	typedef struct packed {
		logic [2:0] req_type;
		logic [7:0] tx_byte;
		logic       sda_in;
	} item_t;

	// One result per tick.
	typedef struct packed {
		logic       scl_out;
		logic       sda_out;
		logic       busy_res;
		logic       done_res;
		logic [1:0] status;
		logic [7:0] rx_byte;
	} result_t;

	// Configuration seen by the sequencer.
	typedef struct packed {
		logic [15:0] phase_delay;
		logic [15:0] ack_timeout;
	} cfg_t;

endpackage

`default_nettype wire

// ===== rtl/core/i2cm_seq.sv =====
`default_nettype none

// Bus phase sequencer: holds the engine state and computes one tick's update.
module i2cm_seq (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             step,
	input  wire i2cm_pkg::item_t  item,
	input  wire i2cm_pkg::cfg_t   cfg,
	output i2cm_pkg::result_t     result
);

	i2cm_pkg::phase_t phase_q, phase_d;
	logic [3:0]  bit_count_q, bit_count_d;
	logic [15:0] hold_count_q, hold_count_d;
	logic [15:0] ack_count_q, ack_count_d;
	logic [7:0]  shift_q, shift_d;
	logic        scl_q, scl_d;
	logic        sda_q, sda_d;
	logic [1:0]  status_q, status_d;
	logic        nack_q, nack_d;
	logic [7:0]  rx_q, rx_d;
	logic        done;
	logic [3:0]  bit_inc;

	assign bit_inc = bit_count_q + 4'd1;

	// Next state for one tick.
	always_comb begin
		phase_d      = phase_q;
		bit_count_d  = bit_count_q;
		hold_count_d = hold_count_q;
		ack_count_d  = ack_count_q;
		shift_d      = shift_q;
		scl_d        = scl_q;
		sda_d        = sda_q;
		status_d     = status_q;
		nack_d       = nack_q;
		rx_d         = rx_q;
		done         = 1'b0;

		if (phase_q == i2cm_pkg::PH_IDLE) begin
			// Idle: take a new command.
			case (item.req_type)
				i2cm_pkg::REQ_START: begin
					phase_d      = i2cm_pkg::PH_ST_REL;
					scl_d        = 1'b1;
					sda_d        = 1'b1;
					hold_count_d = cfg.phase_delay;
				end
				i2cm_pkg::REQ_STOP: begin
					phase_d      = i2cm_pkg::PH_SP_SDA;
					sda_d        = 1'b0;
					hold_count_d = cfg.phase_delay;
				end
				i2cm_pkg::REQ_WRITE: begin
					shift_d      = item.tx_byte;
					bit_count_d  = 4'd0;
					phase_d      = i2cm_pkg::PH_WR_SCL;
					scl_d        = 1'b0;
					hold_count_d = cfg.phase_delay;
				end
				i2cm_pkg::REQ_RD_ACK, i2cm_pkg::REQ_RD_NACK: begin
					nack_d       = (item.req_type == i2cm_pkg::REQ_RD_NACK);
					shift_d      = 8'd0;
					bit_count_d  = 4'd0;
					phase_d      = i2cm_pkg::PH_RD_PREP;
					scl_d        = 1'b0;
					sda_d        = 1'b1;
					hold_count_d = 16'd0;
				end
				default: begin
				end
			endcase
		end else if (hold_count_q != 16'd0) begin
			// Still holding the current phase.
			hold_count_d = hold_count_q - 16'd1;
		end else begin
			// End of phase: act and enter the next one.
			hold_count_d = cfg.phase_delay;
			case (phase_q)
				i2cm_pkg::PH_ST_REL: begin
					if (!item.sda_in) begin
						phase_d      = i2cm_pkg::PH_IDLE;
						hold_count_d = 16'd0;
						status_d     = i2cm_pkg::ST_BUS_BUSY;
						done         = 1'b1;
					end else begin
						phase_d = i2cm_pkg::PH_ST_SDA;
						sda_d   = 1'b0;
					end
				end
				i2cm_pkg::PH_ST_SDA: begin
					phase_d = i2cm_pkg::PH_ST_SCL;
					scl_d   = 1'b0;
				end
				i2cm_pkg::PH_ST_SCL: begin
					phase_d      = i2cm_pkg::PH_IDLE;
					hold_count_d = 16'd0;
					status_d     = item.sda_in ? i2cm_pkg::ST_BUS_ERR : i2cm_pkg::ST_OK;
					done         = 1'b1;
				end
				i2cm_pkg::PH_SP_SDA: begin
					phase_d = i2cm_pkg::PH_SP_SCL;
					scl_d   = 1'b1;
				end
				i2cm_pkg::PH_SP_SCL: begin
					phase_d = i2cm_pkg::PH_SP_REL;
					sda_d   = 1'b1;
				end
				i2cm_pkg::PH_SP_REL: begin
					phase_d      = i2cm_pkg::PH_IDLE;
					hold_count_d = 16'd0;
					status_d     = i2cm_pkg::ST_OK;
					done         = 1'b1;
				end
				i2cm_pkg::PH_WR_SCL: begin
					phase_d = i2cm_pkg::PH_WR_BIT;
					sda_d   = shift_q[7];
					shift_d = {shift_q[6:0], 1'b0};
				end
				i2cm_pkg::PH_WR_BIT: begin
					phase_d = i2cm_pkg::PH_WR_HI;
					scl_d   = 1'b1;
				end
				i2cm_pkg::PH_WR_HI: begin
					phase_d = i2cm_pkg::PH_WR_LO;
					scl_d   = 1'b0;
				end
				i2cm_pkg::PH_WR_LO: begin
					bit_count_d = bit_inc;
					if (bit_inc >= i2cm_pkg::BYTE_BITS) begin
						phase_d = i2cm_pkg::PH_WR_AREL;
						sda_d   = 1'b1;
					end else begin
						phase_d = i2cm_pkg::PH_WR_BIT;
						sda_d   = shift_q[7];
						shift_d = {shift_q[6:0], 1'b0};
					end
				end
				i2cm_pkg::PH_WR_AREL: begin
					phase_d = i2cm_pkg::PH_WR_AHI;
					scl_d   = 1'b1;
				end
				i2cm_pkg::PH_WR_AHI: begin
					phase_d      = i2cm_pkg::PH_WR_POLL;
					hold_count_d = 16'd0;
					ack_count_d  = 16'd0;
				end
				i2cm_pkg::PH_WR_POLL: begin
					// Poll for the slave acknowledge, one check per tick.
					hold_count_d = 16'd0;
					if (!item.sda_in || ack_count_q >= cfg.ack_timeout) begin
						phase_d  = i2cm_pkg::PH_IDLE;
						scl_d    = 1'b0;
						sda_d    = 1'b1;
						status_d = item.sda_in ? i2cm_pkg::ST_NACK : i2cm_pkg::ST_OK;
						done     = 1'b1;
					end else begin
						ack_count_d = ack_count_q + 16'd1;
					end
				end
				i2cm_pkg::PH_RD_PREP: begin
					phase_d = i2cm_pkg::PH_RD_HI;
					scl_d   = 1'b1;
				end
				i2cm_pkg::PH_RD_HI: begin
					shift_d = {shift_q[6:0], item.sda_in};
					phase_d = i2cm_pkg::PH_RD_LO;
					scl_d   = 1'b0;
				end
				i2cm_pkg::PH_RD_LO: begin
					bit_count_d = bit_inc;
					if (bit_inc >= i2cm_pkg::BYTE_BITS) begin
						rx_d    = shift_q;
						phase_d = i2cm_pkg::PH_AK_SDA;
						sda_d   = nack_q;
					end else begin
						phase_d = i2cm_pkg::PH_RD_HI;
						scl_d   = 1'b1;
					end
				end
				i2cm_pkg::PH_AK_SDA: begin
					phase_d = i2cm_pkg::PH_AK_HI;
					scl_d   = 1'b1;
				end
				i2cm_pkg::PH_AK_HI: begin
					phase_d = i2cm_pkg::PH_AK_LO;
					scl_d   = 1'b0;
				end
				i2cm_pkg::PH_AK_LO: begin
					phase_d      = i2cm_pkg::PH_IDLE;
					hold_count_d = 16'd0;
					sda_d        = 1'b1;
					status_d     = i2cm_pkg::ST_OK;
					done         = 1'b1;
				end
				default: begin
					phase_d      = i2cm_pkg::PH_IDLE;
					hold_count_d = 16'd0;
				end
			endcase
		end
	end

	// The result reflects the state after this tick.
	always_comb begin
		result.scl_out  = scl_d;
		result.sda_out  = sda_d;
		result.busy_res = (phase_d != i2cm_pkg::PH_IDLE);
		result.done_res = done;
		result.status   = status_d;
		result.rx_byte  = rx_d;
	end

	// Engine state registers, updated once per tick.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= i2cm_pkg::PH_IDLE;
			bit_count_q  <= 4'd0;
			hold_count_q <= 16'd0;
			ack_count_q  <= 16'd0;
			shift_q      <= 8'd0;
			scl_q        <= 1'b1;
			sda_q        <= 1'b1;
			status_q     <= i2cm_pkg::ST_OK;
			nack_q       <= 1'b0;
			rx_q         <= 8'd0;
		end else if (step) begin
			phase_q      <= phase_d;
			bit_count_q  <= bit_count_d;
			hold_count_q <= hold_count_d;
			ack_count_q  <= ack_count_d;
			shift_q      <= shift_d;
			scl_q        <= scl_d;
			sda_q        <= sda_d;
			status_q     <= status_d;
			nack_q       <= nack_d;
			rx_q         <= rx_d;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/i2c_master_byte_engine_unit.sv =====
// Byte-level I2C master, one timing tick per transaction.
// A tick goes through the input register and then the result register, which may stall.
// Throughput: one tick per cycle if not stalled; the sequencer state updates once per tick.
// Reset (arst_n low, asynchronous): bus idle, SCL and SDA released, status and rx byte zero,
// phase_delay 4 and ack_timeout 100, both pipeline registers empty.
`default_nettype none

module i2c_master_byte_engine_unit (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                item_valid,
	output logic                                     item_stall,
	input  wire i2cm_pkg::item_t                     item,
	output logic                                     result_valid,
	input  wire logic                                result_stall,
	output i2cm_pkg::result_t                        result,
	input  wire logic                                cfg_we,
	input  wire logic [i2cm_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [15:0]                         cfg_wdata
);

	i2cm_pkg::cfg_t    cfg_q;
	logic              valid_s1;
	i2cm_pkg::item_t   item_s1;
	logic              advance;
	i2cm_pkg::result_t seq_result;
	i2cm_pkg::result_t result_s2;
	logic              valid_s2;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.phase_delay <= i2cm_pkg::PHASE_DELAY_RST;
			cfg_q.ack_timeout <= i2cm_pkg::ACK_TIMEOUT_RST;
		end else if (cfg_we) begin
			if (cfg_index == i2cm_pkg::CFG_PHASE_DELAY) begin
				cfg_q.phase_delay <= cfg_wdata;
			end
			if (cfg_index == i2cm_pkg::CFG_ACK_TIMEOUT) begin
				cfg_q.ack_timeout <= cfg_wdata;
			end
		end
	end

	// The tick in the input register moves on unless the result register is blocked.
	assign advance    = valid_s1 && (!valid_s2 || !result_stall);
	assign item_stall = valid_s1 && !advance;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			item_s1 <= item;
		end
	end

	// Phase sequencer.
	i2cm_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.item   (item_s1),
		.cfg    (cfg_q),
		.result (seq_result)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (!result_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2 <= seq_result;
		end
	end

	assign result_valid = valid_s2;
	assign result       = result_s2;

endmodule

`default_nettype wire

// ===== rtl/core/i2cm_checker.sv =====
`default_nettype none
`include "i2c_master_byte_engine_unit_macros.svh"

// Port-level checks for the I2C byte engine.
module i2cm_checker (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                item_valid,
	input  wire logic                                item_stall,
	input  wire logic                                result_valid,
	input  wire logic                                result_stall,
	input  wire i2cm_pkg::result_t                   result
);

	logic in_taken;
	logic out_blocked;
	logic out_done;

	// Handshake events seen on the ports.
	assign in_taken    = item_valid && !item_stall;
	assign out_blocked = result_valid && result_stall;
	assign out_done    = result_valid && result.done_res;

	// An empty result register never blocks the input side.
	`I2CM_ASSERT_NOW(a_empty_no_stall, clk, arst_n, !result_valid, !item_stall, "stall while empty")

	// A blocked result holds still.
	`I2CM_ASSERT_NEXT(a_hold, clk, arst_n, out_blocked, result_valid && $stable(result), "result moved")

	// A finishing command leaves the engine idle.
	`I2CM_ASSERT_NOW(a_done_idle, clk, arst_n, out_done, !result.busy_res, "done while busy")

	// An accepted tick taken while the result register is empty reaches the output.
	`I2CM_ASSERT_NEXT(a_arrive, clk, arst_n, in_taken && !result_valid, ##1 result_valid, "tick lost")

endmodule

bind i2c_master_byte_engine_unit i2cm_checker u_i2cm_checker (.*);

`default_nettype wire

// ===== tb/sv/i2c_master_byte_engine_unit_tb.sv =====
`default_nettype none

module i2c_master_byte_engine_unit_tb;
	import i2cm_pkg::*;

	// Request codes outside the defined set; the engine treats them as no request.
	localparam logic [2:0] REQ_RSVD6 = 3'd6;
	localparam logic [2:0] REQ_RSVD7 = 3'd7;

	// Cycles without any accepted transaction before the run is declared hung.
	localparam int STUCK_LIMIT = 10000;

	typedef struct {
		item_t   it;
		int      reps;   // 0 repeats the tick until the engine is idle again
		bit      chk;
		result_t want;
	} stim_row_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 item_valid = 1'b0;
	logic                 item_stall;
	item_t                item = '0;
	logic                 result_valid;
	logic                 result_stall = 1'b0;
	result_t              result;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [15:0]          cfg_wdata = '0;

	// Expected per-tick bus levels and status, oldest first.
	result_t   tick_result_q[$];
	stim_row_t dir_tab[$];
	item_t     bus_plan[$];
	int        mismatches = 0;
	int        stuck_cycles = 0;
	int        stall_left = 0;
	bit        quiet = 1'b0;

	// Predicted engine state and configuration.
	phase_t      eng_ph;
	logic [3:0]  eng_bits;
	logic [15:0] eng_hold;
	logic [15:0] eng_ackc;
	logic [7:0]  eng_shift;
	logic        eng_scl;
	logic        eng_sda;
	logic [1:0]  eng_status;
	logic        eng_nack_rd;
	logic [7:0]  eng_rx;
	logic        eng_done;
	logic [15:0] cfg_pd;
	logic [15:0] cfg_at;

	i2c_master_byte_engine_unit u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata)
	);

	always #10 clk = ~clk;

	// Engine state right after reset.
	function automatic void engine_reset();
		eng_ph      = PH_IDLE;
		eng_bits    = '0;
		eng_hold    = '0;
		eng_ackc    = '0;
		eng_shift   = '0;
		eng_scl     = 1'b1;
		eng_sda     = 1'b1;
		eng_status  = ST_OK;
		eng_nack_rd = 1'b0;
		eng_rx      = '0;
		eng_done    = 1'b0;
		cfg_pd      = PHASE_DELAY_RST;
		cfg_at      = ACK_TIMEOUT_RST;
	endfunction

	// Entering a phase sets the line levels and reloads the hold counter.
	function automatic void enter_phase(phase_t p, logic scl, logic sda);
		eng_ph   = p;
		eng_scl  = scl;
		eng_sda  = sda;
		eng_hold = cfg_pd;
	endfunction

	function automatic void finish_cmd(logic [1:0] st);
		eng_ph     = PH_IDLE;
		eng_hold   = '0;
		eng_status = st;
		eng_done   = 1'b1;
	endfunction

	// Put the next data bit on SDA, MSB first.
	function automatic void shift_bit_out();
		enter_phase(PH_WR_BIT, eng_scl, eng_shift[7]);
		eng_shift = {eng_shift[6:0], 1'b0};
	endfunction

	// End action of the current phase, taken on the tick after its hold ran out.
	function automatic void end_phase(logic sda_in);
		case (eng_ph)
			PH_ST_REL: begin
				if (!sda_in)
					finish_cmd(ST_BUS_BUSY);
				else
					enter_phase(PH_ST_SDA, eng_scl, 1'b0);
			end
			PH_ST_SDA:  enter_phase(PH_ST_SCL, 1'b0, eng_sda);
			PH_ST_SCL:  finish_cmd(sda_in ? ST_BUS_ERR : ST_OK);
			PH_SP_SDA:  enter_phase(PH_SP_SCL, 1'b1, eng_sda);
			PH_SP_SCL:  enter_phase(PH_SP_REL, eng_scl, 1'b1);
			PH_SP_REL:  finish_cmd(ST_OK);
			PH_WR_SCL:  shift_bit_out();
			PH_WR_BIT:  enter_phase(PH_WR_HI, 1'b1, eng_sda);
			PH_WR_HI:   enter_phase(PH_WR_LO, 1'b0, eng_sda);
			PH_WR_LO: begin
				eng_bits = eng_bits + 4'd1;
				if (eng_bits >= BYTE_BITS)
					enter_phase(PH_WR_AREL, eng_scl, 1'b1);
				else
					shift_bit_out();
			end
			PH_WR_AREL: enter_phase(PH_WR_AHI, 1'b1, eng_sda);
			PH_WR_AHI: begin
				enter_phase(PH_WR_POLL, eng_scl, eng_sda);
				eng_hold = '0;
				eng_ackc = '0;
			end
			PH_WR_POLL: begin
				if (!sda_in) begin
					eng_scl = 1'b0;
					eng_sda = 1'b1;
					finish_cmd(ST_OK);
				end else if (eng_ackc >= cfg_at) begin
					eng_scl = 1'b0;
					eng_sda = 1'b1;
					finish_cmd(ST_NACK);
				end else begin
					eng_ackc = eng_ackc + 16'd1;
				end
			end
			PH_RD_PREP: enter_phase(PH_RD_HI, 1'b1, eng_sda);
			PH_RD_HI: begin
				eng_shift = {eng_shift[6:0], sda_in};
				enter_phase(PH_RD_LO, 1'b0, eng_sda);
			end
			PH_RD_LO: begin
				eng_bits = eng_bits + 4'd1;
				if (eng_bits >= BYTE_BITS) begin
					eng_rx = eng_shift;
					enter_phase(PH_AK_SDA, eng_scl, eng_nack_rd);
				end else begin
					enter_phase(PH_RD_HI, 1'b1, eng_sda);
				end
			end
			PH_AK_SDA:  enter_phase(PH_AK_HI, 1'b1, eng_sda);
			PH_AK_HI:   enter_phase(PH_AK_LO, 1'b0, eng_sda);
			PH_AK_LO: begin
				eng_sda = 1'b1;
				finish_cmd(ST_OK);
			end
			default: begin
				eng_ph   = PH_IDLE;
				eng_hold = '0;
			end
		endcase
	endfunction

	// Advance the engine by one tick and return the levels it shows afterwards.
	function automatic result_t engine_step(item_t t);
		result_t r;
		eng_done = 1'b0;
		if (eng_ph == PH_IDLE) begin
			case (t.req_type)
				REQ_START: enter_phase(PH_ST_REL, 1'b1, 1'b1);
				REQ_STOP:  enter_phase(PH_SP_SDA, eng_scl, 1'b0);
				REQ_WRITE: begin
					eng_shift = t.tx_byte;
					eng_bits  = '0;
					enter_phase(PH_WR_SCL, 1'b0, eng_sda);
				end
				REQ_RD_ACK, REQ_RD_NACK: begin
					eng_nack_rd = (t.req_type == REQ_RD_NACK);
					eng_shift   = '0;
					eng_bits    = '0;
					enter_phase(PH_RD_PREP, 1'b0, 1'b1);
					eng_hold    = '0;
				end
				default: ;
			endcase
		end else if (eng_hold != 16'd0) begin
			eng_hold = eng_hold - 16'd1;
		end else begin
			end_phase(t.sda_in);
		end
		r.scl_out  = eng_scl;
		r.sda_out  = eng_sda;
		r.busy_res = (eng_ph != PH_IDLE);
		r.done_res = eng_done;
		r.status   = eng_status;
		r.rx_byte  = eng_rx;
		return r;
	endfunction

	function automatic result_t res(logic scl, logic sda, logic busy, logic done,
		logic [1:0] st, logic [7:0] rx);
		result_t r;
		r.scl_out  = scl;
		r.sda_out  = sda;
		r.busy_res = busy;
		r.done_res = done;
		r.status   = st;
		r.rx_byte  = rx;
		return r;
	endfunction

	function automatic stim_row_t row(logic [2:0] rq, logic [7:0] tx, logic sda, int reps,
		bit chk, result_t want);
		stim_row_t s;
		s.it.req_type = rq;
		s.it.tx_byte  = tx;
		s.it.sda_in   = sda;
		s.reps        = reps;
		s.chk         = chk;
		s.want        = want;
		return s;
	endfunction

	// Idle length for either side: mostly none or short, now and then long.
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (quiet || r < 60)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		else if (r < 98)
			return $urandom_range(4, 10);
		else
			return $urandom_range(20, 150);
	endfunction

	// SDA as a slave would mostly answer in the phase the engine is in.
	function automatic logic pick_sda();
		case (eng_ph)
			PH_ST_REL:  return ($urandom_range(0, 9) != 0);
			PH_ST_SCL:  return ($urandom_range(0, 9) == 0);
			PH_WR_POLL: return ($urandom_range(0, 4) != 0);
			default:    return 1'($urandom_range(0, 1));
		endcase
	endfunction

	// Present one tick, hold it until accepted, then record its expected result.
	task automatic send_tick(item_t t);
		int g;
		g = gap_len();
		if (g > 0) begin
			item_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		item       <= t;
		item_valid <= 1'b1;
		do
			@(posedge clk);
		while (item_stall);
		tick_result_q.push_back(engine_step(t));
	endtask

	// Run the engine back to idle, then wait until every result has been taken.
	task automatic settle();
		item_t t;
		while (eng_ph != PH_IDLE) begin
			t.req_type = REQ_NONE;
			t.tx_byte  = 8'($urandom);
			t.sda_in   = pick_sda();
			send_tick(t);
		end
		item_valid <= 1'b0;
		while (tick_result_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_regs(logic [15:0] pd, logic [15:0] at);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_PHASE_DELAY;
		cfg_wdata <= pd;
		@(posedge clk);
		cfg_index <= CFG_ACK_TIMEOUT;
		cfg_wdata <= at;
		@(posedge clk);
		cfg_we <= 1'b0;
		cfg_pd = pd;
		cfg_at = at;
	endtask

	// Queue a bus sequence: mostly start, a few bytes, stop; sometimes a stray command.
	task automatic plan_sequence();
		item_t c;
		int    n;
		c.sda_in = 1'b1;
		if ($urandom_range(0, 99) < 85) begin
			c.req_type = REQ_START;
			c.tx_byte  = 8'($urandom);
			bus_plan.push_back(c);
			n = $urandom_range(1, 3);
			repeat (n) begin
				case ($urandom_range(0, 2))
					0:       c.req_type = REQ_WRITE;
					1:       c.req_type = REQ_RD_ACK;
					default: c.req_type = REQ_RD_NACK;
				endcase
				c.tx_byte = 8'($urandom);
				bus_plan.push_back(c);
			end
			c.req_type = REQ_STOP;
			c.tx_byte  = 8'($urandom);
			bus_plan.push_back(c);
		end else begin
			c.req_type = 3'($urandom_range(0, 7));
			c.tx_byte  = 8'($urandom);
			bus_plan.push_back(c);
		end
	endtask

	// Random ticks until the given number of active ones has been sent.
	task automatic run_random(int goal);
		item_t t;
		int    n;
		bit    busy;
		n = 0;
		while (n < goal) begin
			busy = (eng_ph != PH_IDLE);
			if (busy) begin
				t.req_type = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(0, 7)) : REQ_NONE;
				t.tx_byte  = 8'($urandom);
			end else if ($urandom_range(0, 4) == 0) begin
				case ($urandom_range(0, 2))
					0:       t.req_type = REQ_NONE;
					1:       t.req_type = REQ_RSVD6;
					default: t.req_type = REQ_RSVD7;
				endcase
				t.tx_byte = 8'($urandom);
			end else begin
				if (bus_plan.size() == 0)
					plan_sequence();
				t = bus_plan.pop_front();
			end
			t.sda_in = pick_sda();
			if (busy || (t.req_type >= REQ_START && t.req_type <= REQ_RD_NACK))
				n++;
			send_tick(t);
		end
	endtask

	task automatic load_table();
		// After reset: lines released, nothing reported.
		dir_tab.push_back(row(REQ_NONE, 8'h00, 1'b1, 1, 1'b1,
			res(1'b1, 1'b1, 1'b0, 1'b0, ST_OK, 8'h00)));
		// Start with SDA held low by another master.
		dir_tab.push_back(row(REQ_START, 8'h00, 1'b0, 1, 1'b0, '0));
		dir_tab.push_back(row(REQ_NONE, 8'h00, 1'b0, 4, 1'b0, '0));
		dir_tab.push_back(row(REQ_NONE, 8'h00, 1'b0, 1, 1'b1,
			res(1'b1, 1'b1, 1'b0, 1'b1, ST_BUS_BUSY, 8'h00)));
		// Start where SDA fails to follow the pull-down.
		dir_tab.push_back(row(REQ_START, 8'hFF, 1'b1, 1, 1'b0, '0));
		dir_tab.push_back(row(REQ_NONE, 8'hFF, 1'b1, 14, 1'b0, '0));
		dir_tab.push_back(row(REQ_NONE, 8'hFF, 1'b1, 1, 1'b1,
			res(1'b0, 1'b0, 1'b0, 1'b1, ST_BUS_ERR, 8'h00)));
		// Clean start.
		dir_tab.push_back(row(REQ_START, 8'h00, 1'b1, 1, 1'b0, '0));
		dir_tab.push_back(row(REQ_NONE, 8'h00, 1'b1, 5, 1'b0, '0));
		dir_tab.push_back(row(REQ_NONE, 8'h00, 1'b0, 0, 1'b0, '0));
		// Write acknowledged; commands arriving meanwhile are dropped.
		dir_tab.push_back(row(REQ_WRITE, 8'hA5, 1'b1, 1, 1'b0, '0));
		dir_tab.push_back(row(REQ_WRITE, 8'h3C, 1'b0, 3, 1'b0, '0));
		dir_tab.push_back(row(REQ_STOP, 8'h00, 1'b0, 2, 1'b0, '0));
		dir_tab.push_back(row(REQ_NONE, 8'h00, 1'b0, 0, 1'b0, '0));
		dir_tab.push_back(row(REQ_WRITE, 8'hFF, 1'b1, 1, 1'b0, '0));
		dir_tab.push_back(row(REQ_NONE, 8'hFF, 1'b0, 0, 1'b0, '0));
		// Write that no slave acknowledges within the timeout.
		dir_tab.push_back(row(REQ_WRITE, 8'h00, 1'b1, 1, 1'b0, '0));
		dir_tab.push_back(row(REQ_NONE, 8'h00, 1'b1, 0, 1'b1,
			res(1'b0, 1'b1, 1'b0, 1'b1, ST_NACK, 8'h00)));
		// Reads of all ones with ACK and all zeros with NACK.
		dir_tab.push_back(row(REQ_RD_ACK, 8'h00, 1'b1, 1, 1'b0, '0));
		dir_tab.push_back(row(REQ_NONE, 8'h00, 1'b1, 0, 1'b1,
			res(1'b0, 1'b1, 1'b0, 1'b1, ST_OK, 8'hFF)));
		dir_tab.push_back(row(REQ_RD_NACK, 8'hFF, 1'b0, 1, 1'b0, '0));
		dir_tab.push_back(row(REQ_NONE, 8'hFF, 1'b0, 0, 1'b1,
			res(1'b0, 1'b1, 1'b0, 1'b1, ST_OK, 8'h00)));
		// Stop, then the two undefined request codes while idle.
		dir_tab.push_back(row(REQ_STOP, 8'h00, 1'b1, 1, 1'b0, '0));
		dir_tab.push_back(row(REQ_NONE, 8'h00, 1'b1, 0, 1'b0, '0));
		dir_tab.push_back(row(REQ_RSVD6, 8'h55, 1'b1, 1, 1'b1,
			res(1'b1, 1'b1, 1'b0, 1'b0, ST_OK, 8'h00)));
		dir_tab.push_back(row(REQ_RSVD7, 8'hAA, 1'b0, 1, 1'b1,
			res(1'b1, 1'b1, 1'b0, 1'b0, ST_OK, 8'h00)));
	endtask

	// Stimulus and phase sequencing.
	initial begin
		item_t t;
		int    k;
		engine_reset();
		load_table();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_tab[i]) begin
			k = 0;
			do begin
				send_tick(dir_tab[i].it);
				k++;
			end while (dir_tab[i].reps == 0 ? (eng_ph != PH_IDLE) : (k < dir_tab[i].reps));
			if (dir_tab[i].chk)
				tick_result_q[tick_result_q.size() - 1] = dir_tab[i].want;
		end
		settle();

		// Shortest phases and an immediate NACK.
		set_regs(16'd0, 16'd0);
		run_random(250);
		settle();

		// Long phase hold, one stop only, no idling on either side.
		quiet = 1'b1;
		set_regs(16'd120, 16'd1);
		t.req_type = REQ_STOP;
		t.tx_byte  = 8'($urandom);
		t.sda_in   = 1'b1;
		send_tick(t);
		settle();

		// Long ACK poll, run out to a NACK.
		set_regs(16'd0, 16'd150);
		t.req_type = REQ_WRITE;
		t.tx_byte  = 8'($urandom);
		send_tick(t);
		t.req_type = REQ_NONE;
		while (eng_ph != PH_IDLE)
			send_tick(t);
		settle();

		quiet = 1'b0;
		set_regs(16'd1, 16'd1);
		run_random(250);
		settle();

		quiet = 1'($urandom_range(0, 1));
		set_regs(16'($urandom_range(0, 6)), 16'($urandom_range(0, 30)));
		run_random(250);
		settle();

		quiet = 1'b0;
		set_regs(16'd3, 16'($urandom_range(2, 20)));
		run_random(250);
		settle();

		repeat (10) @(posedge clk);
		if (mismatches == 0 && tick_result_q.size() == 0)
			$display("i2c_master_byte_engine_unit regression: pass");
		else
			$display("i2c_master_byte_engine_unit regression: fail");
		$finish;
	end

	// Random back-pressure on the result side.
	always @(posedge clk) begin
		logic nxt;
		nxt = 1'b0;
		if (!quiet) begin
			if (stall_left == 0)
				stall_left = gap_len();
			if (stall_left > 0) begin
				stall_left--;
				nxt = 1'b1;
			end
		end else begin
			stall_left = 0;
		end
		result_stall <= nxt;
	end

	task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			mismatches++;
		end
	endtask

	// Compare every accepted result with the oldest expected one.
	always @(posedge clk) begin
		result_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (tick_result_q.size() == 0) begin
				$error("result transaction with no expected result pending");
				mismatches++;
			end else begin
				want = tick_result_q.pop_front();
				check_field("scl_out", 8'(want.scl_out), 8'(result.scl_out));
				check_field("sda_out", 8'(want.sda_out), 8'(result.sda_out));
				check_field("busy_res", 8'(want.busy_res), 8'(result.busy_res));
				check_field("done_res", 8'(want.done_res), 8'(result.done_res));
				check_field("status", 8'(want.status), 8'(result.status));
				check_field("rx_byte", want.rx_byte, result.rx_byte);
			end
		end
	end

	// Hang detection: too long without any transaction on either channel.
	always @(posedge clk) begin
		if (!arst_n || cfg_we || (item_valid && !item_stall) || (result_valid && !result_stall))
			stuck_cycles = 0;
		else
			stuck_cycles++;
		if (stuck_cycles >= STUCK_LIMIT) begin
			$display("i2c_master_byte_engine_unit regression: fail");
			$finish;
		end
	end

endmodule

`default_nettype wire

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/i2cm_pkg.sv
rtl/core/i2cm_seq.sv
rtl/core/i2c_master_byte_engine_unit.sv
rtl/core/i2cm_checker.sv
tb/sv/i2c_master_byte_engine_unit_tb.sv
